[src/pid_controller_step_assert.svh]
// assertion macros used by the pid controller state machine
`ifndef PID_CONTROLLER_STEP_ASSERT_SVH
`define PID_CONTROLLER_STEP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PIDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PIDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/pidc_pkg.sv]
// types, constants and helpers shared by the pid controller modules
package pidc_pkg;

  localparam int SIG_W         = 32;
  localparam int ERR_W         = 33;
  localparam int DT_W          = 16;
  localparam int INTEG_W       = 48;
  localparam int ACC_W         = 50;
  localparam int PROD_W        = 66;
  localparam int MAG_W         = 64;
  localparam int TERM_W        = 42;
  localparam int SUM_W         = 44;
  localparam int TERM_EXP      = 40;
  localparam int CFG_IDX_W     = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DIV_BITS_CYC  = 2;

  localparam logic signed [SIG_W-1:0] LIMIT_RESET = 32'sd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_DRIVE_FLOOR = 3'd3,
    REG_DRIVE_CEIL  = 3'd4,
    REG_ACCUM_FLOOR = 3'd5,
    REG_ACCUM_CEIL  = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MUL_PROP,
    MUL_ERRDT,
    MUL_ITERM,
    MUL_DERIV
  } mul_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_P,
    S_MUL_I,
    S_ACC,
    S_MUL_IT,
    S_MUL_D,
    S_DSTART,
    S_DIV,
    S_DTERM,
    S_SUM,
    S_OUT
  } state_t;

  typedef struct packed {
    logic     ld_in;
    mul_sel_t mul_sel;
    logic     ld_p;
    logic     ld_integ;
    logic     ld_i;
    logic     div_start;
    logic     clr_d;
    logic     ld_d;
    logic     ld_sum;
    logic     ld_out;
  } cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic first;
    logic div_done;
    logic out_free;
  } sts_t;

  // symmetric saturation of a shifted product to +/- 2^40
  function automatic logic signed [TERM_W-1:0] sat_term(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = {{(PROD_W-TERM_EXP-1){1'b0}}, 1'b1, {TERM_EXP{1'b0}}};
    lo = -hi;
    if (v > hi) begin
      return hi[TERM_W-1:0];
    end else if (v < lo) begin
      return lo[TERM_W-1:0];
    end
    return v[TERM_W-1:0];
  endfunction

endpackage

[src/pid_controller_step.sv]
// top level of the fixed-point pid controller with clamped integrator
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_setpoint, in_measured, in_step_time
//   out      output     out_valid/out_stall  out_drive
//   cfg      input      cfg_we               cfg_index, cfg_wdata
//
// one request at a time: a new request is taken only once the sequence is back in idle;
// the derivative term uses the 32 iterations of the two-bit-a-cycle divider
// with zero step_time or on the first request after reset the divider is bypassed
// rst_n is synchronous: gains clear, limits go to +/-1.0, integrator and history clear
// a result waiting under out_stall holds the sequence in its last step; the next
// request may still be taken once the result register has been loaded
module pid_controller_step #(
  parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [pidc_pkg::SIG_W-1:0]     in_setpoint,
  input  logic signed [pidc_pkg::SIG_W-1:0]     in_measured,
  input  logic        [pidc_pkg::DT_W-1:0]      in_step_time,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [pidc_pkg::SIG_W-1:0]     out_drive,
  input  logic                                  cfg_we,
  input  logic        [pidc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [pidc_pkg::SIG_W-1:0]     cfg_wdata
);

  pidc_pkg::cmd_t cmd;
  pidc_pkg::sts_t sts;

  pidc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  pidc_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_setpoint  (in_setpoint),
    .in_measured  (in_measured),
    .in_step_time (in_step_time),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_drive    (out_drive),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

[src/pidc_div.sv]
// unsigned 64 by 16 bit restoring divider, two quotient bits a cycle
module pidc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pidc_pkg::MAG_W-1:0]   dividend,
  input  logic [pidc_pkg::DT_W-1:0]    divisor,
  output logic                         done,
  output logic [pidc_pkg::MAG_W-1:0]   quotient
);

  localparam int STEPS = pidc_pkg::MAG_W / pidc_pkg::DIV_BITS_CYC;
  localparam int CNT_W = $clog2(STEPS);

  logic                        busy_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [pidc_pkg::DT_W-1:0]   rem_r;
  logic [pidc_pkg::MAG_W-1:0]  quo_r;
  logic [pidc_pkg::DT_W-1:0]   rem_nxt;
  logic [pidc_pkg::MAG_W-1:0]  quo_nxt;

  always_comb begin
    logic [pidc_pkg::DT_W:0] trial;
    logic [pidc_pkg::DT_W:0] diff;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int k = 0; k < pidc_pkg::DIV_BITS_CYC; k++) begin
      trial = {rem_nxt, quo_nxt[pidc_pkg::MAG_W-1]};
      diff  = trial - {1'b0, divisor};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = diff[pidc_pkg::DT_W-1:0];
        quo_nxt = {quo_nxt[pidc_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[pidc_pkg::DT_W-1:0];
        quo_nxt = {quo_nxt[pidc_pkg::MAG_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[src/pidc_ctrl.sv]
// sequencing state machine of the pid controller
`include "pid_controller_step_assert.svh"

module pidc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  pidc_pkg::sts_t  sts_i,
  output pidc_pkg::cmd_t  cmd_o
);

  pidc_pkg::state_t state_r;
  pidc_pkg::state_t state_nxt;
  logic             skip_d;

  assign skip_d = sts_i.first || sts_i.dt_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pidc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pidc_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = pidc_pkg::S_MUL_P;
        end
      end
      pidc_pkg::S_MUL_P:  state_nxt = pidc_pkg::S_MUL_I;
      pidc_pkg::S_MUL_I:  state_nxt = pidc_pkg::S_ACC;
      pidc_pkg::S_ACC:    state_nxt = pidc_pkg::S_MUL_IT;
      pidc_pkg::S_MUL_IT: state_nxt = pidc_pkg::S_MUL_D;
      pidc_pkg::S_MUL_D:  state_nxt = pidc_pkg::S_DSTART;
      pidc_pkg::S_DSTART: state_nxt = skip_d ? pidc_pkg::S_SUM : pidc_pkg::S_DIV;
      pidc_pkg::S_DIV: begin
        if (sts_i.div_done) begin
          state_nxt = pidc_pkg::S_DTERM;
        end
      end
      pidc_pkg::S_DTERM:  state_nxt = pidc_pkg::S_SUM;
      pidc_pkg::S_SUM:    state_nxt = pidc_pkg::S_OUT;
      pidc_pkg::S_OUT: begin
        if (sts_i.out_free) begin
          state_nxt = pidc_pkg::S_IDLE;
        end
      end
      default: state_nxt = pidc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = pidc_pkg::MUL_PROP;
    in_stall      = 1'b1;
    case (state_r)
      pidc_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        cmd_o.ld_in = in_valid;
      end
      pidc_pkg::S_MUL_P: cmd_o.mul_sel = pidc_pkg::MUL_PROP;
      pidc_pkg::S_MUL_I: begin
        cmd_o.mul_sel = pidc_pkg::MUL_ERRDT;
        cmd_o.ld_p    = 1'b1;
      end
      pidc_pkg::S_ACC:    cmd_o.ld_integ = !sts_i.dt_zero;
      pidc_pkg::S_MUL_IT: cmd_o.mul_sel  = pidc_pkg::MUL_ITERM;
      pidc_pkg::S_MUL_D: begin
        cmd_o.mul_sel = pidc_pkg::MUL_DERIV;
        cmd_o.ld_i    = 1'b1;
      end
      pidc_pkg::S_DSTART: begin
        cmd_o.div_start = !skip_d;
        cmd_o.clr_d     = skip_d;
      end
      pidc_pkg::S_DIV:   cmd_o.ld_d   = 1'b0;
      pidc_pkg::S_DTERM: cmd_o.ld_d   = 1'b1;
      pidc_pkg::S_SUM:   cmd_o.ld_sum = 1'b1;
      pidc_pkg::S_OUT:   cmd_o.ld_out = sts_i.out_free;
      default: in_stall = 1'b1;
    endcase
  end

  `PIDC_ASSERT_IMP(a_div_needs_step, cmd_o.div_start, !sts_i.dt_zero && !sts_i.first, "divider started without a usable step")
  `PIDC_ASSERT_NXT(a_accept_starts, in_valid && !in_stall, state_r == pidc_pkg::S_MUL_P, "accepted request did not start the sequence")
  `PIDC_ASSERT_IMP(a_out_slot_free, cmd_o.ld_out, sts_i.out_free, "result loaded over a waiting result")
  `PIDC_ASSERT_IMP(a_integ_step, cmd_o.ld_integ, !sts_i.dt_zero, "integral updated on a zero step")

endmodule

[src/pidc_dpath.sv]
// datapath of the pid controller: registers, shared multiplier, clamps, divider
module pidc_dpath #(
  parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic signed [pidc_pkg::SIG_W-1:0]     in_setpoint,
  input  logic signed [pidc_pkg::SIG_W-1:0]     in_measured,
  input  logic        [pidc_pkg::DT_W-1:0]      in_step_time,
  input  logic                                  cfg_we,
  input  logic        [pidc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [pidc_pkg::SIG_W-1:0]     cfg_wdata,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic signed [pidc_pkg::SIG_W-1:0]     out_drive,
  input  pidc_pkg::cmd_t                        cmd_i,
  output pidc_pkg::sts_t                        sts_o
);

  localparam int SIG_W   = pidc_pkg::SIG_W;
  localparam int ERR_W   = pidc_pkg::ERR_W;
  localparam int DT_W    = pidc_pkg::DT_W;
  localparam int INTEG_W = pidc_pkg::INTEG_W;
  localparam int ACC_W   = pidc_pkg::ACC_W;
  localparam int PROD_W  = pidc_pkg::PROD_W;
  localparam int MAG_W   = pidc_pkg::MAG_W;
  localparam int TERM_W  = pidc_pkg::TERM_W;
  localparam int SUM_W   = pidc_pkg::SUM_W;
  localparam int DOWN    = (FRAC_BITS > DT_W) ? FRAC_BITS - DT_W : 0;
  localparam int UP      = (FRAC_BITS < DT_W) ? DT_W - FRAC_BITS : 0;
  localparam logic [MAG_W-1:0] D_LIM   = MAG_W'(1) << (pidc_pkg::TERM_EXP - UP);
  localparam logic [MAG_W-1:0] D_SAT   = MAG_W'(1) << pidc_pkg::TERM_EXP;

  logic signed [SIG_W-1:0]   prop_gain_r;
  logic signed [SIG_W-1:0]   integ_gain_r;
  logic signed [SIG_W-1:0]   deriv_gain_r;
  logic signed [SIG_W-1:0]   drive_floor_r;
  logic signed [SIG_W-1:0]   drive_ceil_r;
  logic signed [SIG_W-1:0]   accum_floor_r;
  logic signed [SIG_W-1:0]   accum_ceil_r;

  logic signed [ERR_W-1:0]   err_r;
  logic        [DT_W-1:0]    dt_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [TERM_W-1:0]  p_r;
  logic signed [TERM_W-1:0]  i_r;
  logic signed [TERM_W-1:0]  d_r;
  logic                      d_neg_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [ERR_W-1:0]   last_err_r;
  logic                      first_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic                      out_valid_r;
  logic signed [SIG_W-1:0]   out_drive_r;

  logic signed [ERR_W-1:0]   mul_a;
  logic signed [ERR_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [PROD_W-1:0]  prod_sh;
  logic signed [TERM_W-1:0]  term_v;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_hi;
  logic signed [ACC_W-1:0]   acc_lo;
  logic signed [ACC_W-1:0]   acc_min;
  logic signed [ACC_W-1:0]   acc_cl;
  logic signed [ERR_W:0]     diff_w;
  logic signed [ERR_W-1:0]   diff_sat;
  logic signed [PROD_W-1:0]  prod_neg;
  logic        [MAG_W-1:0]   d_dividend;
  logic                      div_done;
  logic        [MAG_W-1:0]   div_q;
  logic        [MAG_W-1:0]   q_dn;
  logic        [MAG_W-1:0]   d_mag;
  logic signed [TERM_W-1:0]  d_mag_t;
  logic signed [SUM_W-1:0]   ceil_x;
  logic signed [SUM_W-1:0]   floor_x;
  logic signed [SUM_W-1:0]   sum_min;
  logic signed [SUM_W-1:0]   sum_cl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r   <= '0;
      integ_gain_r  <= '0;
      deriv_gain_r  <= '0;
      drive_floor_r <= -pidc_pkg::LIMIT_RESET;
      drive_ceil_r  <= pidc_pkg::LIMIT_RESET;
      accum_floor_r <= -pidc_pkg::LIMIT_RESET;
      accum_ceil_r  <= pidc_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (pidc_pkg::cfg_reg_t'(cfg_index))
        pidc_pkg::REG_PROP_GAIN:   prop_gain_r   <= cfg_wdata;
        pidc_pkg::REG_INTEG_GAIN:  integ_gain_r  <= cfg_wdata;
        pidc_pkg::REG_DERIV_GAIN:  deriv_gain_r  <= cfg_wdata;
        pidc_pkg::REG_DRIVE_FLOOR: drive_floor_r <= cfg_wdata;
        pidc_pkg::REG_DRIVE_CEIL:  drive_ceil_r  <= cfg_wdata;
        pidc_pkg::REG_ACCUM_FLOOR: accum_floor_r <= cfg_wdata;
        pidc_pkg::REG_ACCUM_CEIL:  accum_ceil_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // shared multiplier operand selection
  always_comb begin
    case (cmd_i.mul_sel)
      pidc_pkg::MUL_PROP: begin
        mul_a = err_r;
        mul_b = {prop_gain_r[SIG_W-1], prop_gain_r};
      end
      pidc_pkg::MUL_ERRDT: begin
        mul_a = err_r;
        mul_b = {{(ERR_W-DT_W){1'b0}}, dt_r};
      end
      pidc_pkg::MUL_ITERM: begin
        mul_a = {integ_r[INTEG_W-1], integ_r[INTEG_W-1:DT_W]};
        mul_b = {integ_gain_r[SIG_W-1], integ_gain_r};
      end
      pidc_pkg::MUL_DERIV: begin
        mul_a = diff_sat;
        mul_b = {deriv_gain_r[SIG_W-1], deriv_gain_r};
      end
      default: begin
        mul_a = err_r;
        mul_b = {prop_gain_r[SIG_W-1], prop_gain_r};
      end
    endcase
  end

  assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign prod_sh = prod_r >>> FRAC_BITS;
  assign term_v  = pidc_pkg::sat_term(prod_sh);

  // integrator with clamp, floor wins over ceiling
  assign acc     = {{(ACC_W-INTEG_W){integ_r[INTEG_W-1]}}, integ_r} + prod_r[ACC_W-1:0];
  assign acc_hi  = {{(ACC_W-SIG_W-DT_W){accum_ceil_r[SIG_W-1]}}, accum_ceil_r, {DT_W{1'b0}}};
  assign acc_lo  = {{(ACC_W-SIG_W-DT_W){accum_floor_r[SIG_W-1]}}, accum_floor_r, {DT_W{1'b0}}};
  assign acc_min = (acc > acc_hi) ? acc_hi : acc;
  assign acc_cl  = (acc_min < acc_lo) ? acc_lo : acc_min;

  // error difference saturated to 33 bits
  assign diff_w   = {err_r[ERR_W-1], err_r} - {last_err_r[ERR_W-1], last_err_r};
  assign diff_sat = (diff_w[ERR_W] != diff_w[ERR_W-1]) ?
                    {diff_w[ERR_W], {(ERR_W-1){~diff_w[ERR_W]}}} : diff_w[ERR_W-1:0];

  assign prod_neg   = -prod_r;
  assign d_dividend = prod_r[PROD_W-1] ? prod_neg[MAG_W-1:0] : prod_r[MAG_W-1:0];

  pidc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd_i.div_start),
    .dividend (d_dividend),
    .divisor  (dt_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_dn    = div_q >> DOWN;
  assign d_mag   = (q_dn > D_LIM) ? D_SAT : (q_dn << UP);
  assign d_mag_t = {1'b0, d_mag[TERM_W-2:0]};

  // output clamp, floor wins over ceiling
  assign ceil_x  = SUM_W'(drive_ceil_r);
  assign floor_x = SUM_W'(drive_floor_r);
  assign sum_min = (sum_r > ceil_x) ? ceil_x : sum_r;
  assign sum_cl  = (sum_min < floor_x) ? floor_x : sum_min;

  // controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      last_err_r  <= '0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_i.ld_integ) begin
        integ_r <= acc_cl[INTEG_W-1:0];
      end
      if (cmd_i.ld_sum) begin
        last_err_r <= err_r;
        first_r    <= 1'b0;
      end
      if (cmd_i.ld_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (cmd_i.ld_in) begin
      err_r <= {in_setpoint[SIG_W-1], in_setpoint} - {in_measured[SIG_W-1], in_measured};
      dt_r  <= in_step_time;
    end
    if (cmd_i.ld_p) begin
      p_r <= term_v;
    end
    if (cmd_i.ld_i) begin
      i_r <= term_v;
    end
    if (cmd_i.div_start) begin
      d_neg_r <= prod_r[PROD_W-1];
    end
    if (cmd_i.clr_d) begin
      d_r <= '0;
    end else if (cmd_i.ld_d) begin
      d_r <= d_neg_r ? -d_mag_t : d_mag_t;
    end
    if (cmd_i.ld_sum) begin
      sum_r <= SUM_W'(p_r) + SUM_W'(i_r) + SUM_W'(d_r);
    end
    if (cmd_i.ld_out) begin
      out_drive_r <= sum_cl[SIG_W-1:0];
    end
  end

  assign sts_o.dt_zero  = (dt_r == '0);
  assign sts_o.first    = first_r;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

endmodule
